// ===== hdl/chunked_dense_slot_table_defines.svh =====
// assertion helpers, expect clk and rst_n in scope
`ifndef CHUNKED_DENSE_SLOT_TABLE_DEFINES_SVH
`define CHUNKED_DENSE_SLOT_TABLE_DEFINES_SVH

// same-cycle implication
`define CDST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cdst_pkg.sv =====
package cdst_pkg;

  localparam int STORE_ROWS = 4096;
  localparam int MAX_CHUNKS = 64;

  localparam int ID_W        = 32;
  localparam int REQ_W       = 2;
  localparam int LOC_CHUNK_W = 6;
  localparam int LOC_ROW_W   = 12;
  localparam int STATUS_W    = 2;
  localparam int CAP_W       = 13;
  localparam int CAP_MAX     = 4096;
  localparam int CAP_RESET   = 64;

  localparam int ADDR_W  = $clog2(STORE_ROWS);
  localparam int CNT_W   = $clog2(STORE_ROWS + 1);
  localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);
  localparam int CMP_W   = ((CHUNK_W > LOC_CHUNK_W) ? CHUNK_W : LOC_CHUNK_W) + 1;
  localparam int POS_W   = LOC_CHUNK_W + CAP_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_COUNT  = 2'd3
  } req_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [LOC_CHUNK_W-1:0] chunk;
    logic [LOC_ROW_W-1:0]   row;
    logic                   moved;
    logic [CAP_W-1:0]       row_count;
    logic                   use_rdata;
  } result_t;

endpackage

// ===== hdl/cdst_store.sv =====
module cdst_store (
  input  logic                      clk,
  input  cdst_pkg::mem_req_t        req,
  output logic [cdst_pkg::ID_W-1:0] rdata
);
  import cdst_pkg::*;

  logic [ID_W-1:0] mem [STORE_ROWS];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/cdst_ctrl.sv =====
module cdst_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [cdst_pkg::CAP_W-1:0]       cfg_data,
  output logic                             cfg_ready,
  input  logic                             in_valid,
  input  logic [cdst_pkg::REQ_W-1:0]       in_req_type,
  input  logic [cdst_pkg::ID_W-1:0]        in_entity_in,
  input  logic [cdst_pkg::LOC_CHUNK_W-1:0] in_loc_chunk,
  input  logic [cdst_pkg::LOC_ROW_W-1:0]   in_loc_row,
  output logic                             in_ready,
  input  logic                             out_free,
  output logic                             fin_valid,
  output cdst_pkg::result_t                res,
  input  logic [cdst_pkg::ID_W-1:0]        rdata,
  output cdst_pkg::mem_req_t               mem_req
);
  import cdst_pkg::*;
  `include "chunked_dense_slot_table_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic [CHUNK_W-1:0]     chunks_open_r, chunks_open_nxt;
  logic [CAP_W-1:0]       last_fill_r, last_fill_nxt;
  logic [CNT_W-1:0]       total_rows_r, total_rows_nxt;

  req_t                   req_r;
  logic [ID_W-1:0]        ent_r;
  logic [LOC_CHUNK_W-1:0] c_r;
  logic [LOC_ROW_W-1:0]   r_r;
  result_t                res_r, res_nxt;
  logic [ADDR_W-1:0]      hole_r, hole_nxt;

  logic                   accept;
  logic                   cfg_wr;
  logic [CMP_W-1:0]       c_ext, co_ext;
  logic [CAP_W-1:0]       rows;
  logic                   loc_ok;
  logic [POS_W-1:0]       pos;
  logic                   pos_in;
  logic [CNT_W-1:0]       last;
  logic                   need_new;
  logic                   full;
  logic                   mv;
  logic [CAP_W-1:0]       lf_dec;
  logic [CAP_W-1:0]       cap_clamped;

  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_FIN) && out_free);
  assign accept    = in_valid && in_ready;
  assign fin_valid = (state_r == S_FIN);
  assign res       = res_r;

  // location decode
  always_comb begin
    c_ext  = CMP_W'(c_r);
    co_ext = CMP_W'(chunks_open_r);
    if (c_ext >= co_ext) begin
      rows = '0;
    end else if (c_ext + CMP_W'(1) == co_ext) begin
      rows = last_fill_r;
    end else begin
      rows = cap_r;
    end
    loc_ok   = CAP_W'(r_r) < rows;
    pos      = POS_W'(c_r) * POS_W'(cap_r) + POS_W'(r_r);
    pos_in   = pos < POS_W'(STORE_ROWS);
    last     = total_rows_r - CNT_W'(1);
    need_new = (chunks_open_r == '0) || (last_fill_r >= cap_r);
    full     = (total_rows_r >= CNT_W'(STORE_ROWS)) ||
               (need_new && (chunks_open_r >= CHUNK_W'(MAX_CHUNKS)));
    mv       = pos_in && (pos != POS_W'(last));
    lf_dec   = last_fill_r - CAP_W'(1);
  end

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (cfg_data > CAP_W'(CAP_MAX)) begin
      cap_clamped = CAP_W'(CAP_MAX);
    end else begin
      cap_clamped = cfg_data;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cap_nxt         = cap_r;
    chunks_open_nxt = chunks_open_r;
    last_fill_nxt   = last_fill_r;
    total_rows_nxt  = total_rows_r;
    res_nxt         = res_r;
    hole_nxt        = hole_r;
    mem_req         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        res_nxt   = '0;
        hole_nxt  = pos[ADDR_W-1:0];
        case (req_r)
          REQ_ADD: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = total_rows_r[ADDR_W-1:0];
              mem_req.wdata = ent_r;
              if (need_new) begin
                res_nxt.chunk   = LOC_CHUNK_W'(chunks_open_r);
                res_nxt.row     = '0;
                chunks_open_nxt = chunks_open_r + CHUNK_W'(1);
                last_fill_nxt   = CAP_W'(1);
              end else begin
                res_nxt.chunk = LOC_CHUNK_W'(chunks_open_r - CHUNK_W'(1));
                res_nxt.row   = last_fill_r[LOC_ROW_W-1:0];
                last_fill_nxt = last_fill_r + CAP_W'(1);
              end
              total_rows_nxt = total_rows_r + CNT_W'(1);
            end
          end
          REQ_REMOVE: begin
            if (!loc_ok) begin
              res_nxt.status = ST_BAD_LOC;
            end else begin
              mem_req.re        = 1'b1;
              mem_req.raddr     = last[ADDR_W-1:0];
              res_nxt.moved     = mv;
              res_nxt.use_rdata = mv;
              total_rows_nxt    = last;
              last_fill_nxt     = lf_dec;
              if ((lf_dec == '0) && (chunks_open_r > CHUNK_W'(1))) begin
                chunks_open_nxt = chunks_open_r - CHUNK_W'(1);
                last_fill_nxt   = cap_r;
              end
            end
          end
          REQ_READ: begin
            if (!loc_ok) begin
              res_nxt.status = ST_BAD_LOC;
            end else begin
              mem_req.re        = pos_in;
              mem_req.raddr     = pos[ADDR_W-1:0];
              res_nxt.use_rdata = pos_in;
            end
          end
          REQ_COUNT: begin
            if (c_ext >= co_ext) begin
              res_nxt.status = ST_BAD_LOC;
            end else begin
              res_nxt.row_count = rows;
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          // hole write-back with the last id read in S_EXEC
          mem_req.we    = res_r.moved;
          mem_req.waddr = hole_r;
          mem_req.wdata = rdata;
          state_nxt     = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      cap_nxt         = cap_clamped;
      chunks_open_nxt = '0;
      last_fill_nxt   = '0;
      total_rows_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cap_r         <= CAP_W'(CAP_RESET);
      chunks_open_r <= '0;
      last_fill_r   <= '0;
      total_rows_r  <= '0;
    end else begin
      state_r       <= state_nxt;
      cap_r         <= cap_nxt;
      chunks_open_r <= chunks_open_nxt;
      last_fill_r   <= last_fill_nxt;
      total_rows_r  <= total_rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    hole_r <= hole_nxt;
    if (accept) begin
      req_r <= req_t'(in_req_type);
      ent_r <= in_entity_in;
      c_r   <= in_loc_chunk;
      r_r   <= in_loc_row;
    end
  end

  `CDST_ASSERT_NOW(a_rows_bound, 1'b1, total_rows_r <= CNT_W'(STORE_ROWS),
    "row total above store size")
  `CDST_ASSERT_NOW(a_empty_closed, chunks_open_r == '0,
    (total_rows_r == '0) && (last_fill_r == '0), "rows held with no chunk open")
  `CDST_ASSERT_NOW(a_fill_bound, 1'b1, last_fill_r <= cap_r,
    "last chunk fill above capacity")
  `CDST_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC,
    "accepted beat not executed")

endmodule

// ===== hdl/chunked_dense_slot_table.sv =====
// Chunked dense slot table: a dense array of 32-bit ids in chunks of cfg rows.
// Input channel (in_*): one request beat: add, remove (swap-remove), read id,
//   or chunk row count. Output channel (out_*): exactly one result beat each.
// Config channel (cfg_*): writes the chunk capacity (0 acts as 1, values above
//   4096 act as 4096) and empties the table; cfg_ready is high only when the
//   sequencer is idle.
// Sequencing: a new request is taken only in S_IDLE or S_FIN, so each one
//   passes S_EXEC, where the id store read is issued, then S_FIN, its
//   write-back (remove reads the last id, then writes it into the hole); the
//   next beat is taken in the write-back cycle.
// Output register: a finished result waits there; the sequencer stalls in its
//   write-back cycle while the register is full and out_ready is low, and
//   in_ready drops until the result moves.
// Reset: chunks, fill and row total clear, capacity returns to 64; the id
//   store is not cleared, since only written rows are ever read.
module chunked_dense_slot_table (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cdst_pkg::CAP_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cdst_pkg::REQ_W-1:0]            in_req_type,
  input  logic [cdst_pkg::ID_W-1:0]             in_entity_in,
  input  logic [cdst_pkg::LOC_CHUNK_W-1:0]      in_loc_chunk,
  input  logic [cdst_pkg::LOC_ROW_W-1:0]        in_loc_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cdst_pkg::STATUS_W-1:0]         out_status,
  output logic [cdst_pkg::LOC_CHUNK_W-1:0]      out_chunk,
  output logic [cdst_pkg::LOC_ROW_W-1:0]        out_row,
  output logic [cdst_pkg::ID_W-1:0]             out_entity_out,
  output logic                                  out_moved,
  output logic [cdst_pkg::CAP_W-1:0]            out_row_count
);
  import cdst_pkg::*;

  mem_req_t        mem_req;
  logic [ID_W-1:0] rdata;
  result_t         res;
  logic            fin_valid;
  logic            out_free;
  logic            out_valid_r;

  assign out_free = !out_valid_r || out_ready;

  cdst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_req_type  (in_req_type),
    .in_entity_in (in_entity_in),
    .in_loc_chunk (in_loc_chunk),
    .in_loc_row   (in_loc_row),
    .in_ready     (in_ready),
    .out_free     (out_free),
    .fin_valid    (fin_valid),
    .res          (res),
    .rdata        (rdata),
    .mem_req      (mem_req)
  );

  cdst_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_free) begin
      out_status     <= res.status;
      out_chunk      <= res.chunk;
      out_row        <= res.row;
      out_entity_out <= res.use_rdata ? rdata : '0;
      out_moved      <= res.moved;
      out_row_count  <= res.row_count;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== tb/tb.sv =====
module tb;
  import cdst_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [LOC_CHUNK_W-1:0] chunk;
    logic [LOC_ROW_W-1:0]   row;
    logic [ID_W-1:0]        entity;
    logic                   moved;
    logic [CAP_W-1:0]       row_count;
  } slot_resp_t;

  typedef struct {
    bit                     is_cfg;
    req_t                   req;
    logic [ID_W-1:0]        ent;
    logic [LOC_CHUNK_W-1:0] c;
    logic [LOC_ROW_W-1:0]   r;
    bit                     typed;
    slot_resp_t             exp;
  } dir_row_t;

  localparam slot_resp_t RESP_NONE = '0;
  localparam slot_resp_t RESP_BAD  = '{ST_BAD_LOC, 6'd0, 12'd0, 32'd0, 1'b0, 13'd0};
  localparam slot_resp_t RESP_FULL = '{ST_FULL, 6'd0, 12'd0, 32'd0, 1'b0, 13'd0};
  localparam int N_DIR = 27;
  localparam int N_PHASE = 10;
  localparam int HOLD_CYCLES = 300;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [REQ_W-1:0]       in_req_type = '0;
  logic [ID_W-1:0]        in_entity_in = '0;
  logic [LOC_CHUNK_W-1:0] in_loc_chunk = '0;
  logic [LOC_ROW_W-1:0]   in_loc_row = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [LOC_CHUNK_W-1:0] out_chunk;
  logic [LOC_ROW_W-1:0]   out_row;
  logic [ID_W-1:0]        out_entity_out;
  logic                   out_moved;
  logic [CAP_W-1:0]       out_row_count;

  chunked_dense_slot_table dut (.*);

  // mirror of the table
  logic [ID_W-1:0] id_mirror [STORE_ROWS];
  int cap_rows = CAP_RESET;
  int n_chunks = 0;
  int tail_fill = 0;
  int n_rows = 0;

  slot_resp_t due_results [$];
  int err_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int cfg_writes = 0;
  bit idle_on = 1'b1;
  bit hold_out = 1'b0;

  int phase_caps [N_PHASE] = '{2, 7, 64, 100, 4096, 3, 1, 8191, 0, 13};

  dir_row_t dir_tab [N_DIR] = '{
    '{0, REQ_COUNT,  32'h0,         6'd0,  12'd0,    1, RESP_BAD},
    '{0, REQ_READ,   32'h0,         6'd0,  12'd0,    1, RESP_BAD},
    '{0, REQ_REMOVE, 32'h0,         6'd0,  12'd0,    1, RESP_BAD},
    '{0, REQ_ADD,    32'hFFFF_FFFF, 6'd63, 12'd4095, 1, RESP_NONE},
    '{0, REQ_ADD,    32'h0000_0000, 6'd0,  12'd0,    1,
      '{ST_OK, 6'd0, 12'd1, 32'd0, 1'b0, 13'd0}},
    '{0, REQ_ADD,    32'hA5A5_5A5A, 6'd0,  12'd0,    1,
      '{ST_OK, 6'd0, 12'd2, 32'd0, 1'b0, 13'd0}},
    '{0, REQ_READ,   32'h0,         6'd0,  12'd0,    1,
      '{ST_OK, 6'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, 13'd0}},
    '{0, REQ_READ,   32'h0,         6'd0,  12'd3,    1, RESP_BAD},
    '{0, REQ_COUNT,  32'h0,         6'd0,  12'd0,    1,
      '{ST_OK, 6'd0, 12'd0, 32'd0, 1'b0, 13'd3}},
    '{0, REQ_COUNT,  32'h0,         6'd63, 12'd0,    1, RESP_BAD},
    '{0, REQ_REMOVE, 32'h0,         6'd0,  12'd0,    0, RESP_NONE},
    '{0, REQ_REMOVE, 32'h0,         6'd0,  12'd1,    0, RESP_NONE},
    '{0, REQ_READ,   32'h0,         6'd63, 12'd4095, 1, RESP_BAD},
    '{1, REQ_ADD,    32'd0,         6'd0,  12'd0,    0, RESP_NONE},
    '{0, REQ_ADD,    32'h1111_1111, 6'd0,  12'd0,    1, RESP_NONE},
    '{0, REQ_ADD,    32'h2222_2222, 6'd0,  12'd0,    1,
      '{ST_OK, 6'd1, 12'd0, 32'd0, 1'b0, 13'd0}},
    '{0, REQ_ADD,    32'h3333_3333, 6'd0,  12'd0,    1,
      '{ST_OK, 6'd2, 12'd0, 32'd0, 1'b0, 13'd0}},
    '{0, REQ_REMOVE, 32'h0,         6'd1,  12'd0,    0, RESP_NONE},
    '{0, REQ_COUNT,  32'h0,         6'd2,  12'd0,    0, RESP_NONE},
    '{0, REQ_READ,   32'h0,         6'd1,  12'd0,    0, RESP_NONE},
    '{0, REQ_REMOVE, 32'h0,         6'd0,  12'd0,    0, RESP_NONE},
    '{0, REQ_REMOVE, 32'h0,         6'd0,  12'd0,    0, RESP_NONE},
    '{0, REQ_COUNT,  32'h0,         6'd0,  12'd0,    0, RESP_NONE},
    '{1, REQ_ADD,    32'd8191,      6'd0,  12'd0,    0, RESP_NONE},
    '{0, REQ_ADD,    32'h8000_0001, 6'd0,  12'd0,    1, RESP_NONE},
    '{0, REQ_READ,   32'h0,         6'd0,  12'd4095, 1, RESP_BAD},
    '{1, REQ_ADD,    32'd4096,      6'd0,  12'd0,    0, RESP_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int rows_held(int c);
    if (c >= n_chunks) return 0;
    if (c + 1 == n_chunks) return tail_fill;
    return cap_rows;
  endfunction

  function automatic slot_resp_t table_step(req_t req, logic [ID_W-1:0] ent, int c, int r);
    slot_resp_t res;
    bit need_new;
    int hole;
    int last;
    int pos;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_ADD: begin
        need_new = (n_chunks == 0) || (tail_fill >= cap_rows);
        if (n_rows >= STORE_ROWS || (need_new && n_chunks >= MAX_CHUNKS)) begin
          res.status = ST_FULL;
        end else begin
          if (need_new) begin
            n_chunks++;
            tail_fill = 0;
          end
          res.chunk = LOC_CHUNK_W'(n_chunks - 1);
          res.row = LOC_ROW_W'(tail_fill);
          id_mirror[n_rows] = ent;
          tail_fill++;
          n_rows++;
        end
      end
      REQ_REMOVE: begin
        if (r >= rows_held(c)) begin
          res.status = ST_BAD_LOC;
        end else begin
          hole = c * cap_rows + r;
          last = n_rows - 1;
          if (hole < STORE_ROWS && last < STORE_ROWS && hole != last) begin
            res.entity = id_mirror[last];
            id_mirror[hole] = id_mirror[last];
            res.moved = 1'b1;
          end
          n_rows--;
          tail_fill--;
          if (tail_fill == 0 && n_chunks > 1) begin
            n_chunks--;
            tail_fill = cap_rows;
          end
        end
      end
      REQ_READ: begin
        if (r >= rows_held(c)) begin
          res.status = ST_BAD_LOC;
        end else begin
          pos = c * cap_rows + r;
          if (pos < STORE_ROWS) res.entity = id_mirror[pos];
        end
      end
      default: begin
        if (c >= n_chunks) res.status = ST_BAD_LOC;
        else res.row_count = CAP_W'(rows_held(c));
      end
    endcase
    return res;
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 18) : 0;
  endfunction

  task automatic send_req(req_t req, logic [ID_W-1:0] ent, logic [LOC_CHUNK_W-1:0] c,
                          logic [LOC_ROW_W-1:0] r, bit typed, slot_resp_t typed_exp);
    int gap;
    slot_resp_t pred;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_entity_in <= ent;
    in_loc_chunk <= c;
    in_loc_row <= r;
    do @(posedge clk); while (!in_ready);
    pred = table_step(req, ent, int'(c), int'(r));
    if (pred.status == ST_FULL) n_full++;
    due_results.insert(due_results.size(), typed ? typed_exp : pred);
    n_sent++;
  endtask

  task automatic write_cap(logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_rows = (v == 0) ? 1 : (v > CAP_MAX) ? CAP_MAX : int'(v);
    n_chunks = 0;
    tail_fill = 0;
    n_rows = 0;
    cfg_writes++;
  endtask

  task automatic rand_item();
    int pick;
    int p;
    req_t req;
    logic [LOC_CHUNK_W-1:0] c;
    logic [LOC_ROW_W-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 45) req = REQ_ADD;
    else if (pick < 70) req = REQ_REMOVE;
    else if (pick < 88) req = REQ_READ;
    else req = REQ_COUNT;
    if (n_rows > 0 && $urandom_range(0, 99) < 85) begin
      p = $urandom_range(0, n_rows - 1);
      c = LOC_CHUNK_W'(p / cap_rows);
      r = LOC_ROW_W'(p % cap_rows);
    end else begin
      c = LOC_CHUNK_W'($urandom_range(0, 63));
      r = LOC_ROW_W'($urandom_range(0, 4095));
    end
    send_req(req, $urandom, c, r, 1'b0, RESP_NONE);
  endtask

  task automatic fill_adds(int n);
    repeat (n) send_req(REQ_ADD, $urandom, '0, '0, 1'b0, RESP_NONE);
  endtask

  task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  initial begin : result_check
    slot_resp_t want;
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_checked++;
      if (due_results.size() == 0) begin
        $error("result beat with no request pending");
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("status", ID_W'(want.status), ID_W'(out_status));
        check_field("out_chunk", ID_W'(want.chunk), ID_W'(out_chunk));
        check_field("out_row", ID_W'(want.row), ID_W'(out_row));
        check_field("entity_out", want.entity, out_entity_out);
        check_field("moved", ID_W'(want.moved), ID_W'(out_moved));
        check_field("row_count", ID_W'(want.row_count), ID_W'(out_row_count));
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_cap(dir_tab[i].ent[CAP_W-1:0]);
      else send_req(dir_tab[i].req, dir_tab[i].ent, dir_tab[i].c, dir_tab[i].r,
                    dir_tab[i].typed, dir_tab[i].exp);
    end

    // chunk limit, one row per chunk
    write_cap(13'd1);
    fill_adds(MAX_CHUNKS);
    send_req(REQ_ADD, 32'h5A5A_A5A5, '0, '0, 1'b1, RESP_FULL);
    repeat (20) rand_item();

    // back to back with the output held off
    write_cap(13'd4096);
    idle_on = 1'b0;
    hold_out = 1'b1;
    fill_adds(40);
    idle_on = 1'b1;
    repeat (20) rand_item();

    foreach (phase_caps[k]) begin
      write_cap(CAP_W'(phase_caps[k]));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (33) rand_item();
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d capacity writes", n_sent, n_checked,
             cfg_writes);
    $display("%0d adds refused by a full table, one output stall of %0d cycles", n_full,
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
